// File: rtl/olse_pkg.sv
package olse_pkg;

    localparam int CAPACITY   = 64;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int VALUE_BITS = 32;

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [3:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_BACK  = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_DEL_VALUE = 4'd6,
        OP_SEARCH    = 4'd7,
        OP_GET_AT    = 4'd8,
        OP_CLEAR     = 4'd9
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_BOUNDS    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ALLOC, S_WALK_RD, S_WALK_CHK,
        S_LINK_RD, S_LINK_WR, S_UNL_RD, S_UNL_WR, S_TAIL_RD, S_TAIL_SET, S_DONE
    } state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;        // capture request
        logic walk_init;   // cursor <= head, index <= 0
        logic walk_rd;     // read node at cursor
        logic walk_step;   // cursor <= forward link, index++
        logic alloc;       // pick lowest free slot
        logic link_rd;     // read neighbor links of target
        logic link_wr;     // write new node and splice
        logic unl_rd;      // read links of victim
        logic unl_wr;      // splice victim out
        logic set_head;    // head <= new slot (front insert)
        logic set_tail_tgt;// victim <= backward link of head (back delete)
        logic clear;       // empty the list
        logic set_status;
        logic [2:0] status;
        logic capture_val; // result_value <= read data
        logic capture_pos; // found_position <= index
    } cmd_t;

    typedef struct packed {
        op_t    op;
        logic   empty;
        logic   full;
        logic   pos_zero;
        logic   pos_lt_len;
        logic   at_target;   // index == position
        logic   walk_end;    // index == length
        logic   match;       // read value equals request value
    } stat_t;

endpackage

// File: rtl/olse_datapath.sv
module olse_datapath
    import olse_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [3:0]             s_operation,
    input  logic signed [31:0]     s_item_value,
    input  logic [5:0]             s_item_position,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    output logic [2:0]             status_o,
    output logic signed [31:0]     result_value_o,
    output logic [5:0]             found_position_o,
    output logic [6:0]             entry_count_o
);

    // Node memories; reset leaves them undefined.
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];
    slot_t                 fwd_mem [CAPACITY];
    slot_t                 bwd_mem [CAPACITY];

    logic [CAPACITY-1:0]   used_reg;
    slot_t                 head_reg;
    count_t                len_reg;

    logic [3:0]            op_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [5:0]            pos_reg;
    slot_t                 cur_reg;    // walk cursor / victim / target
    count_t                idx_reg;
    slot_t                 new_reg;    // allocated slot
    logic [VALUE_BITS-1:0] rd_val_reg;
    slot_t                 rd_fwd_reg;
    slot_t                 rd_bwd_reg;
    logic [2:0]            status_reg;
    logic [VALUE_BITS-1:0] rval_reg;
    logic [5:0]            fpos_reg;

    // Lowest free slot
    slot_t free_slot;
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_slot = slot_t'(i);
            end
        end
    end

    // Memory read port (registered)
    always_ff @(posedge aclk) begin
        if (cmd.walk_rd || cmd.link_rd || cmd.unl_rd) begin
            rd_val_reg <= val_mem[cur_reg];
            rd_fwd_reg <= fwd_mem[cur_reg];
            rd_bwd_reg <= bwd_mem[cur_reg];
        end
    end

    // Memory writes: link and unlink splices
    always_ff @(posedge aclk) begin
        if (cmd.link_wr) begin
            val_mem[new_reg] <= val_reg;
            if (len_reg == '0) begin
                fwd_mem[new_reg] <= new_reg;
                bwd_mem[new_reg] <= new_reg;
            end else begin
                fwd_mem[new_reg]    <= cur_reg;
                bwd_mem[new_reg]    <= rd_bwd_reg;
                fwd_mem[rd_bwd_reg] <= new_reg;
                bwd_mem[cur_reg]    <= new_reg;
            end
        end
        if (cmd.unl_wr && len_reg > count_t'(1)) begin
            fwd_mem[rd_bwd_reg] <= rd_fwd_reg;
            bwd_mem[rd_fwd_reg] <= rd_bwd_reg;
        end
    end

    // Control and bookkeeping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            head_reg   <= '0;
            len_reg    <= '0;
            status_reg <= ST_OK;
        end else begin
            if (cmd.link_wr) begin
                used_reg[new_reg] <= 1'b1;
                len_reg           <= len_reg + count_t'(1);
                if (len_reg == '0 || cmd.set_head) begin
                    head_reg <= new_reg;
                end
            end
            if (cmd.unl_wr) begin
                used_reg[cur_reg] <= 1'b0;
                len_reg           <= len_reg - count_t'(1);
                if (len_reg <= count_t'(1)) begin
                    head_reg <= '0;
                end else if (cur_reg == head_reg) begin
                    head_reg <= rd_fwd_reg;
                end
            end
            if (cmd.clear) begin
                used_reg <= '0;
                head_reg <= '0;
                len_reg  <= '0;
            end
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
        end
    end

    // Request capture and walk cursor
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            val_reg  <= s_item_value;
            pos_reg  <= s_item_position;
            rval_reg <= '0;
            fpos_reg <= '0;
        end
        if (cmd.walk_init) begin
            cur_reg <= head_reg;
            idx_reg <= '0;
        end
        if (cmd.set_tail_tgt) begin
            cur_reg <= rd_bwd_reg;
        end
        if (cmd.walk_step) begin
            cur_reg <= rd_fwd_reg;
            idx_reg <= idx_reg + count_t'(1);
        end
        if (cmd.alloc) begin
            new_reg <= free_slot;
        end
        if (cmd.capture_val) begin
            rval_reg <= rd_val_reg;
        end
        if (cmd.capture_pos) begin
            fpos_reg <= idx_reg[5:0];
        end
    end

    // Status to the controller
    always_comb begin
        stat.op         = op_t'(op_reg);
        stat.empty      = (len_reg == '0);
        stat.full       = (len_reg == count_t'(CAPACITY));
        stat.pos_zero   = (pos_reg == '0);
        stat.pos_lt_len = (count_t'(pos_reg) < len_reg);
        stat.at_target  = (idx_reg == count_t'(pos_reg));
        stat.walk_end   = (idx_reg == len_reg);
        stat.match      = (rd_val_reg == val_reg);
    end

    assign status_o         = status_reg;
    assign result_value_o   = rval_reg;
    assign found_position_o = fpos_reg;
    assign entry_count_o    = len_reg;

endmodule

// File: rtl/olse_ctrl.sv
module olse_ctrl
    import olse_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                cmd.walk_init  = 1'b1;
                state_next     = S_DONE;
                case (stat.op)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                        if (stat.full) begin
                            cmd.status = ST_FULL;
                        end else if (stat.op != OP_INS_AT || stat.pos_zero) begin
                            cmd.alloc  = 1'b1;
                            state_next = S_ALLOC;
                        end else if (stat.pos_lt_len) begin
                            cmd.alloc  = 1'b1;
                            state_next = S_WALK_RD;
                        end else begin
                            cmd.status = ST_BOUNDS;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                        if (stat.empty) begin
                            cmd.status = ST_EMPTY;
                        end else if (stat.op == OP_DEL_BACK) begin
                            state_next = S_TAIL_RD;
                        end else if (stat.op == OP_DEL_FRONT || stat.pos_zero) begin
                            state_next = S_UNL_RD;
                        end else if (stat.pos_lt_len) begin
                            state_next = S_WALK_RD;
                        end else begin
                            cmd.status = ST_BOUNDS;
                        end
                    end
                    OP_DEL_VALUE, OP_SEARCH: begin
                        if (stat.empty) begin
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.status = ST_NOT_FOUND;
                            state_next = S_WALK_RD;
                        end
                    end
                    OP_GET_AT: begin
                        if (stat.empty) begin
                            cmd.status = ST_EMPTY;
                        end else if (stat.pos_lt_len) begin
                            state_next = S_WALK_RD;
                        end else begin
                            cmd.status = ST_BOUNDS;
                        end
                    end
                    OP_CLEAR: cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            // Insert at front, at back or at position zero: target is head
            S_ALLOC: begin
                state_next = S_LINK_RD;
            end
            S_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                case (stat.op)
                    OP_DEL_VALUE, OP_SEARCH: begin
                        if (stat.match) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_OK;
                            if (stat.op == OP_SEARCH) begin
                                cmd.capture_pos = 1'b1;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_UNL_RD;
                            end
                        end else begin
                            cmd.walk_step = 1'b1;
                            state_next    = S_WALK_RD;
                        end
                    end
                    default: begin
                        if (stat.at_target) begin
                            if (stat.op == OP_GET_AT) begin
                                cmd.capture_val = 1'b1;
                                state_next      = S_DONE;
                            end else if (stat.op == OP_DEL_AT) begin
                                state_next = S_UNL_RD;
                            end else begin
                                state_next = S_LINK_RD;
                            end
                        end else begin
                            cmd.walk_step = 1'b1;
                            state_next    = S_WALK_RD;
                        end
                    end
                endcase
                if ((stat.op == OP_DEL_VALUE || stat.op == OP_SEARCH) && !stat.match
                    && stat.walk_end) begin
                    cmd.walk_step = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_LINK_RD: begin
                cmd.link_rd = 1'b1;
                state_next  = S_LINK_WR;
            end
            S_LINK_WR: begin
                cmd.link_wr  = 1'b1;
                cmd.set_head = (stat.op == OP_INS_FRONT)
                               || (stat.op == OP_INS_AT && stat.pos_zero);
                state_next   = S_DONE;
            end
            S_UNL_RD: begin
                cmd.unl_rd = 1'b1;
                state_next = S_UNL_WR;
            end
            S_UNL_WR: begin
                cmd.unl_wr      = 1'b1;
                cmd.capture_val = 1'b1;
                state_next      = S_DONE;
            end
            // Back delete: read head, its backward link is the tail
            S_TAIL_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_TAIL_SET;
            end
            S_TAIL_SET: begin
                cmd.set_tail_tgt = 1'b1;
                state_next       = S_UNL_RD;
            end
            S_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/ordered_list_store_engine_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// request   | s_valid / s_ready  | s_operation, s_item_value, s_item_position
// result    | m_valid / m_ready  | m_status, m_result_value, m_found_position,
//           |                    | m_entry_count
//
// One request at a time. Position and value ops walk the list link by link:
// a registered node read, then a compare. After each result the engine returns
// to idle before it accepts the next request. aresetn is synchronous; it empties
// the list. The result stays on m_* until taken, and no request is accepted
// meanwhile.
module ordered_list_store_engine_core
    import olse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_operation,
    input  logic signed [31:0] s_item_value,
    input  logic [5:0]         s_item_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_result_value,
    output logic [5:0]         m_found_position,
    output logic [6:0]         m_entry_count
);

    cmd_t  cmd;
    stat_t stat;

    olse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    olse_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_operation      (s_operation),
        .s_item_value     (s_item_value),
        .s_item_position  (s_item_position),
        .cmd              (cmd),
        .stat             (stat),
        .status_o         (m_status),
        .result_value_o   (m_result_value),
        .found_position_o (m_found_position),
        .entry_count_o    (m_entry_count)
    );

endmodule

// File: tb/sv/ordered_list_store_engine_core_tb.sv
`timescale 1ns / 1ps

module ordered_list_store_engine_core_tb
    import olse_pkg::*;
();

    localparam int CAP = CAPACITY;

    // One expected response of the list engine
    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
        logic [5:0]  fpos;
        logic [6:0]  count;
    } list_resp_t;

    // Shadow of the linked list plus the queue of expected responses
    class list_scoreboard;
        logic [31:0] vals[CAP];
        int          fwd[CAP];
        int          bwd[CAP];
        bit          used[CAP];
        int          head;
        int          len;
        list_resp_t  pending[$];
        int          errors;

        function void wipe();
            for (int i = 0; i < CAP; i++) begin
                used[i] = 0;
                fwd[i] = 0;
                bwd[i] = 0;
                vals[i] = 0;
            end
            head = 0;
            len = 0;
        endfunction

        function int walk_to(int p);
            int s;
            s = head;
            for (int i = 0; i < p; i++) s = fwd[s];
            return s;
        endfunction

        // New node goes into the lowest free slot, before node t
        function int splice_in(logic [31:0] v, int t);
            int s;
            int p;
            s = 0;
            for (int i = 0; i < CAP; i++) begin
                if (!used[i]) begin
                    s = i;
                    break;
                end
            end
            used[s] = 1;
            vals[s] = v;
            if (len == 0) begin
                fwd[s] = s;
                bwd[s] = s;
                head = s;
            end else begin
                p = bwd[t];
                fwd[s] = t;
                bwd[s] = p;
                fwd[p] = s;
                bwd[t] = s;
            end
            len++;
            return s;
        endfunction

        function logic [31:0] splice_out(int s);
            logic [31:0] v;
            v = vals[s];
            if (len <= 1) begin
                head = 0;
            end else begin
                fwd[bwd[s]] = fwd[s];
                bwd[fwd[s]] = bwd[s];
                if (s == head) head = fwd[s];
            end
            used[s] = 0;
            len--;
            return v;
        endfunction

        function void note_request(logic [3:0] op, logic [31:0] v, logic [5:0] pos);
            list_resp_t r;
            int s;
            int p;
            p = int'(pos);
            r.status = ST_OK;
            r.value = 0;
            r.fpos = 0;
            case (op)
                OP_INS_FRONT, OP_INS_BACK: begin
                    if (len >= CAP) r.status = ST_FULL;
                    else begin
                        s = splice_in(v, head);
                        if (op == OP_INS_FRONT) head = s;
                    end
                end
                OP_INS_AT: begin
                    if (len >= CAP) r.status = ST_FULL;
                    else if (p == 0) head = splice_in(v, head);
                    else if (p < len) s = splice_in(v, walk_to(p));
                    else r.status = ST_BOUNDS;
                end
                OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                    if (len == 0) r.status = ST_EMPTY;
                    else if (op == OP_DEL_FRONT || (op == OP_DEL_AT && p == 0))
                        r.value = splice_out(head);
                    else if (op == OP_DEL_BACK) r.value = splice_out(bwd[head]);
                    else if (p < len) r.value = splice_out(walk_to(p));
                    else r.status = ST_BOUNDS;
                end
                OP_DEL_VALUE, OP_SEARCH: begin
                    if (len == 0) r.status = ST_EMPTY;
                    else begin
                        r.status = ST_NOT_FOUND;
                        s = head;
                        for (int i = 0; i < len; i++) begin
                            if (vals[s] == v) begin
                                r.status = ST_OK;
                                if (op == OP_DEL_VALUE) r.value = splice_out(s);
                                else r.fpos = 6'(i);
                                break;
                            end
                            s = fwd[s];
                        end
                    end
                end
                OP_GET_AT: begin
                    if (len == 0) r.status = ST_EMPTY;
                    else if (p < len) r.value = vals[walk_to(p)];
                    else r.status = ST_BOUNDS;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < CAP; i++) used[i] = 0;
                    head = 0;
                    len = 0;
                end
                default: ;
            endcase
            r.count = 7'(len);
            pending.push_back(r);
        endfunction

        function void check_response(logic [2:0] st, logic [31:0] v, logic [5:0] fp,
                                     logic [6:0] cnt);
            list_resp_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response, exp none got status=%0d", $time, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (v !== e.value) begin
                $display("%0t: value exp %h got %h", $time, e.value, v);
                errors++;
            end
            if (fp !== e.fpos) begin
                $display("%0t: position exp %0d got %0d", $time, e.fpos, fp);
                errors++;
            end
            if (cnt !== e.count) begin
                $display("%0t: count exp %0d got %0d", $time, e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [3:0]         s_operation = 0;
    logic signed [31:0] s_item_value = 0;
    logic [5:0]         s_item_position = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [2:0]         m_status;
    logic signed [31:0] m_result_value;
    logic [5:0]         m_found_position;
    logic [6:0]         m_entry_count;

    list_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #2 aclk = ~aclk;

    ordered_list_store_engine_core dut (.*);

    // Receiver: random stalls, check on each accepted transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_response(m_status, m_result_value, m_found_position, m_entry_count);
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid drops only while idling between transactions or when draining
    task automatic send_request(logic [3:0] op, logic [31:0] v, logic [5:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_operation <= op;
        s_item_value <= v;
        s_item_position <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, v, pos);
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // Values mostly drawn from a small pool so searches and deletes by value hit often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(3);
            default: return $urandom_range(7);
        endcase
    endfunction

    task automatic random_burst(int n, int fill_bias);
        logic [3:0] op;
        int         lim;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < fill_bias) op = 4'($urandom_range(2));
            else if ($urandom_range(199) == 0) op = OP_CLEAR;
            else if ($urandom_range(49) == 0) op = 4'(10 + $urandom_range(5));
            else op = 4'($urandom_range(8));
            lim = (sb.len > 0) ? sb.len : 1;
            send_request(op, pick_value(),
                         ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(lim)));
        end
    endtask

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb.wipe();
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty-list errors, extremes, every operation
        send_request(OP_DEL_FRONT, 0, 0);
        send_request(OP_GET_AT, 0, 0);
        send_request(OP_SEARCH, 5, 0);
        send_request(OP_DEL_VALUE, 5, 0);
        send_request(OP_INS_AT, 7, 3);
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_INS_FRONT, 32'h7fff_ffff, 0);
        send_request(OP_INS_BACK, 32'h8000_0000, 63);
        send_request(OP_INS_AT, 32'hffff_ffff, 1);
        send_request(OP_INS_AT, 1, 0);
        send_request(OP_INS_AT, 2, 4);
        send_request(OP_SEARCH, 32'h8000_0000, 0);
        send_request(OP_SEARCH, 9, 0);
        send_request(OP_GET_AT, 0, 3);
        send_request(OP_GET_AT, 0, 63);
        send_request(OP_DEL_AT, 0, 2);
        send_request(OP_DEL_AT, 0, 9);
        send_request(OP_DEL_VALUE, 32'h7fff_ffff, 0);
        send_request(OP_DEL_BACK, 0, 0);
        send_request(4'd15, 32'hffff_ffff, 63);
        send_request(OP_DEL_AT, 0, 0);
        // Fill to capacity, then hit the full pool
        for (int i = 0; i < CAP; i++) send_request(OP_INS_BACK, i, 0);
        send_request(OP_INS_AT, 3, 5);
        send_request(OP_INS_FRONT, 3, 0);
        send_request(OP_GET_AT, 0, 63);
        send_request(OP_DEL_AT, 0, 63);
        send_request(OP_CLEAR, 0, 0);

        // Random phases with different idle mixes
        send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(300, 45);
        wait_drained();
        send_idle_pct = 57; recv_stall_pct = 0;  random_burst(300, 40);
        send_idle_pct = 0;  recv_stall_pct = 57; random_burst(300, 35);
        send_idle_pct = 15; recv_stall_pct = 15; random_burst(300, 40);
        send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(50, 10);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: files.f
rtl/olse_pkg.sv
rtl/olse_datapath.sv
rtl/olse_ctrl.sv
rtl/ordered_list_store_engine_core.sv
tb/sv/ordered_list_store_engine_core_tb.sv
